@@ rtl/core/swmf_pkg.sv @@
package swmf_pkg;

  localparam int DATA_W          = 32;
  localparam int WINDOW_SIZE_DEF = 5;

  typedef logic signed [DATA_W-1:0] sample_t;

  // What a cell shows its neighbors: its stored value, whether the new item
  // sorts strictly below that value, and whether the element leaving the
  // window sits at this cell or below it.
  typedef struct packed {
    sample_t value;
    logic    lt;
    logic    del_seen;
  } nb_t;

endpackage

@@ rtl/core/swmf_stream_if.sv @@
interface swmf_sample_if
  import swmf_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swmf_median_if
  import swmf_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

@@ rtl/core/swmf_cell.sv @@
module swmf_cell
  import swmf_pkg::*;
#(
  parameter int              AGE_W   = 3,
  parameter logic [AGE_W-1:0] OLDEST  = '0,
  parameter logic [AGE_W-1:0] RST_AGE = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  sample_t          new_sample,
  input  nb_t              lo_nb,
  input  logic [AGE_W-1:0] lo_age,
  input  nb_t              hi_nb,
  input  logic [AGE_W-1:0] hi_age,
  output nb_t              my_nb,
  output logic [AGE_W-1:0] my_age,
  output sample_t          value_nxt
);

  sample_t          value_r;
  logic [AGE_W-1:0] age_r;
  logic [AGE_W-1:0] age_nxt;
  logic             lt_me;
  logic             del_me;

  typedef enum logic [1:0] {
    SEL_LO,
    SEL_SELF,
    SEL_HI,
    SEL_NEW
  } sel_t;

  sel_t sel;

  assign lt_me  = new_sample < value_r;
  assign del_me = age_r == OLDEST;

  assign my_nb.value    = value_r;
  assign my_nb.lt       = lt_me;
  assign my_nb.del_seen = lo_nb.del_seen | del_me;
  assign my_age         = age_r;

  // Three regions relative to the leaving element: below it the row shifts
  // up to make room, at it the gap is filled, above it the row shifts down.
  always_comb begin
    if (!lo_nb.del_seen && !del_me) begin
      sel = lo_nb.lt ? SEL_LO : (lt_me ? SEL_NEW : SEL_SELF);
    end else if (!lo_nb.del_seen) begin
      sel = !hi_nb.lt ? SEL_HI : (lo_nb.lt ? SEL_LO : SEL_NEW);
    end else begin
      sel = !hi_nb.lt ? SEL_HI : (lt_me ? SEL_SELF : SEL_NEW);
    end
  end

  always_comb begin
    unique case (sel)
      SEL_LO: begin
        value_nxt = lo_nb.value;
        age_nxt   = lo_age + 1'b1;
      end
      SEL_SELF: begin
        value_nxt = value_r;
        age_nxt   = age_r + 1'b1;
      end
      SEL_HI: begin
        value_nxt = hi_nb.value;
        age_nxt   = hi_age + 1'b1;
      end
      default: begin
        value_nxt = new_sample;
        age_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      age_r   <= RST_AGE;
    end else if (shift_en) begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

@@ rtl/core/sliding_window_median_filter.sv @@
// Result: the median of an item appears on the output in the cycle after the
// item is accepted.
// Throughput: one item per cycle while the output moves; every cell of the
// sorted row updates in the same cycle, so the row never stalls the input.
// Reset (rst_n low, synchronous): the window holds zeros, ages count the
// zeros out in slot order, and no result is pending.
module sliding_window_median_filter
  import swmf_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  swmf_sample_if.sink    in_if,
  swmf_median_if.source  out_if
);

  localparam int AGE_W = $clog2(WINDOW_SIZE);
  localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WINDOW_SIZE - 1);
  localparam int MID = WINDOW_SIZE >> 1;

  // The window is kept as a row of cells sorted in ascending signed order.
  // Each cell carries its value and its age in items; the cell whose age has
  // reached WINDOW_SIZE-1 holds the oldest sample, which the new item
  // replaces. Each cell decides its next value from its own compare and those
  // of its two neighbors, plus one flag that ripples up the row telling
  // whether the leaving element lies at or below a cell.

  nb_t              cell_nb  [WINDOW_SIZE];
  logic [AGE_W-1:0] cell_age [WINDOW_SIZE];
  sample_t          cell_nxt [WINDOW_SIZE];

  logic    accept;
  logic    out_valid_r;
  sample_t median_r;

  // The output register frees as soon as its item is taken, so a new item
  // is accepted while the previous result is being handed over.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    localparam logic [AGE_W-1:0] RST_AGE = AGE_W'(WINDOW_SIZE - 1 - i);
    nb_t              lo_nb;
    nb_t              hi_nb;
    logic [AGE_W-1:0] lo_age;
    logic [AGE_W-1:0] hi_age;

    // Below the first cell stands minus infinity with nothing leaving; above
    // the last cell stands plus infinity.
    if (i == 0) begin : g_lo_edge
      assign lo_nb  = '{value: '0, lt: 1'b0, del_seen: 1'b0};
      assign lo_age = '0;
    end else begin : g_lo_link
      assign lo_nb  = cell_nb[i-1];
      assign lo_age = cell_age[i-1];
    end

    if (i == WINDOW_SIZE - 1) begin : g_hi_edge
      assign hi_nb  = '{value: '0, lt: 1'b1, del_seen: 1'b1};
      assign hi_age = '0;
    end else begin : g_hi_link
      assign hi_nb  = cell_nb[i+1];
      assign hi_age = cell_age[i+1];
    end

    swmf_cell #(
      .AGE_W   (AGE_W),
      .OLDEST  (OLDEST),
      .RST_AGE (RST_AGE)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (accept),
      .new_sample (in_if.sample),
      .lo_nb      (lo_nb),
      .lo_age     (lo_age),
      .hi_nb      (hi_nb),
      .hi_age     (hi_age),
      .my_nb      (cell_nb[i]),
      .my_age     (cell_age[i]),
      .value_nxt  (cell_nxt[i])
    );
  end

  // The middle cell's next value is the median of the updated window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median_r <= cell_nxt[MID];
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.median = median_r;

endmodule

@@ rtl/core/swmf_checker.sv @@
module swmf_checker
  import swmf_pkg::*;
  (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t median
);

  // An accepted item always yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // With no result pending the block must take input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A result cannot appear without an accepted item.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready))
    else $error("result without an accepted item");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(median))
    else $error("stalled result changed");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .median    (out_if.median)
);
